### src/assert_macros.svh
// assert_macros.svh: concurrent assertion macros used by the checker file pfi_checker.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Condition that must hold in the cycle after reset is seen high.
`define ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("assertion failed: state after reset");

`endif

### src/pfi_pkg.sv
// pfi_pkg: shared constants, item and state types of the polyphase interpolator.
// Used by every module of the block; depends on nothing.
package pfi_pkg;

   // Default sizes of the filter.
   localparam int MAX_FACTOR_DEF = 32;
   localparam int TAPS_DEF       = 16;

   // Field widths fixed by the interface.
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 18;
   localparam int INDEX_W   = 10;
   localparam int FACTOR_W  = 6;
   localparam int OUT_SHIFT = 16;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 6'd1;

   // Output saturation limits.
   localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

   // Request kinds, encoded as on the req_type port.
   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_COEF   = 1'b1
   } pfi_kind_type;

   // One classified request as it travels through the queue.
   typedef struct packed {
      pfi_kind_type                kind;
      logic                        start_of_block;
      logic signed [SAMPLE_W-1:0]  sample_re;
      logic signed [SAMPLE_W-1:0]  sample_im;
      logic [INDEX_W-1:0]          coef_index;
      logic signed [COEF_W-1:0]    coef_value;
      logic                        index_ok;
   } pfi_item_type;

   // Sequencer states of the back end.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_SCALE,
      ST_EMIT
   } pfi_state_type;

endpackage

### src/pfi_ram.sv
// pfi_ram: generic single-write, single-read RAM with registered read data.
// Depends on pfi_pkg for its default sizes only.
module pfi_ram #(
   parameter int WIDTH = pfi_pkg::COEF_W,
   parameter int DEPTH = pfi_pkg::MAX_FACTOR_DEF * pfi_pkg::TAPS_DEF + 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/pfi_front.sv
// pfi_front: accepts request beats, classifies them and holds the factor register.
// Depends on pfi_pkg; feeds pfi_queue.
module pfi_front #(
   parameter int MAX_FACTOR = pfi_pkg::MAX_FACTOR_DEF,
   parameter int PHASE_TAPS = pfi_pkg::TAPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic signed [pfi_pkg::SAMPLE_W-1:0]  req_sample_re,
   input  logic signed [pfi_pkg::SAMPLE_W-1:0]  req_sample_im,
   input  logic                                 req_start_of_block,
   input  logic [pfi_pkg::INDEX_W-1:0]          req_coef_index,
   input  logic signed [pfi_pkg::COEF_W-1:0]    req_coef_value,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pfi_pkg::FACTOR_W-1:0]         csr_upsample_factor,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output pfi_pkg::pfi_item_type                push_item,
   output logic [$clog2(MAX_FACTOR+1)-1:0]      act_factor
);
   import pfi_pkg::*;

   localparam int STORE_DEPTH = MAX_FACTOR * PHASE_TAPS + 1;
   localparam int FACT_W      = $clog2(MAX_FACTOR + 1);

   logic [FACTOR_W-1:0] factor_ff;
   logic [FACTOR_W-1:0] factor_in;

   // Factor register takes a write on every configuration beat.
   always_comb begin
      factor_in = factor_ff;
      if (csr_valid && csr_ready) begin
         factor_in = csr_upsample_factor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_RESET;
      end else begin
         factor_ff <= factor_in;
      end
   end

   assign csr_ready = 1'b1;

   // Zero acts as one, values above the maximum are clamped.
   always_comb begin
      if (factor_ff == '0) begin
         act_factor = FACT_W'(1);
      end else if (32'(factor_ff) > 32'(MAX_FACTOR)) begin
         act_factor = FACT_W'(MAX_FACTOR);
      end else begin
         act_factor = FACT_W'(factor_ff);
      end
   end

   // Classify the beat and flag coefficient writes that land inside the store.
   always_comb begin
      push_item.kind           = pfi_kind_type'(req_type);
      push_item.start_of_block = req_start_of_block;
      push_item.sample_re      = req_sample_re;
      push_item.sample_im      = req_sample_im;
      push_item.coef_index     = req_coef_index;
      push_item.coef_value     = req_coef_value;
      push_item.index_ok       = (32'(req_coef_index) < 32'(STORE_DEPTH));
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

### src/pfi_queue.sv
// pfi_queue: short register FIFO of classified requests between front and back.
// Depends on pfi_pkg for the item type.
module pfi_queue #(
   parameter int DEPTH = pfi_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  pfi_pkg::pfi_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output pfi_pkg::pfi_item_type pop_item
);
   import pfi_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pfi_item_type     entries_ff [DEPTH];
   pfi_item_type     entries_in [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer wrap, occupancy and entry write.
   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         entries_in[wr_ptr_ff] = push_item;
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

endmodule

### src/pfi_back.sv
// pfi_back: history line, coefficient RAM and the multiply-accumulate sequencer.
// Depends on pfi_pkg and pfi_ram; drains pfi_queue and drives the response beats.
module pfi_back #(
   parameter int MAX_FACTOR = pfi_pkg::MAX_FACTOR_DEF,
   parameter int PHASE_TAPS = pfi_pkg::TAPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  pfi_pkg::pfi_item_type                pop_item,
   input  logic [$clog2(MAX_FACTOR+1)-1:0]      act_factor,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pfi_pkg::SAMPLE_W-1:0]  rsp_out_re,
   output logic signed [pfi_pkg::SAMPLE_W-1:0]  rsp_out_im,
   output logic                                 rsp_last_of_run,
   output logic                                 rsp_saturated
);
   import pfi_pkg::*;

   localparam int HALF        = PHASE_TAPS / 2;
   localparam int HIST_DEPTH  = PHASE_TAPS + 1;
   localparam int STORE_DEPTH = MAX_FACTOR * PHASE_TAPS + 1;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int J_W         = $clog2(HIST_DEPTH);
   localparam int LA_W        = $clog2(HALF + 1);
   localparam int FACT_W      = $clog2(MAX_FACTOR + 1);
   localparam int CI_W        = $clog2((PHASE_TAPS + 2) * MAX_FACTOR);
   localparam int PROD_W      = SAMPLE_W + COEF_W;
   localparam int ACC_W       = PROD_W + $clog2(HIST_DEPTH);
   localparam int SCALED_W    = ACC_W + FACT_W + 1;
   localparam int SHIFT_W     = SCALED_W - OUT_SHIFT;
   localparam logic signed [SHIFT_W-1:0] HI_LIM = SHIFT_W'(OUT_MAX);
   localparam logic signed [SHIFT_W-1:0] LO_LIM = SHIFT_W'(OUT_MIN);

   pfi_state_type state_ff, state_in;

   // History line, newest sample at position zero.
   logic signed [SAMPLE_W-1:0] hist_re_ff [HIST_DEPTH];
   logic signed [SAMPLE_W-1:0] hist_re_in [HIST_DEPTH];
   logic signed [SAMPLE_W-1:0] hist_im_ff [HIST_DEPTH];
   logic signed [SAMPLE_W-1:0] hist_im_in [HIST_DEPTH];
   logic [LA_W-1:0]            la_ff, la_in;

   // Phase and tap counters.
   logic [FACT_W-1:0] l_ff, l_in;
   logic [CI_W-1:0]   limit_ff, limit_in;
   logic [FACT_W-1:0] p_ff, p_in;
   logic [CI_W-1:0]   ci_ff, ci_in;
   logic [J_W-1:0]    j_ff, j_in;
   logic              drain_ff, drain_in;

   // Multiply-accumulate pipeline.
   logic                       s1_ff, s1_in;
   logic signed [SAMPLE_W-1:0] h1_re_ff, h1_re_in, h1_im_ff, h1_im_in;
   logic                       s2_ff, s2_in;
   logic signed [PROD_W-1:0]   prod_re_ff, prod_re_in, prod_im_ff, prod_im_in;
   logic signed [ACC_W-1:0]    acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [SCALED_W-1:0] scaled_re_ff, scaled_re_in, scaled_im_ff, scaled_im_in;

   // Output register.
   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_re_ff, out_re_in, out_im_ff, out_im_in;
   logic                       out_last_ff, out_last_in;
   logic                       out_sat_ff, out_sat_in;

   // Combinational helpers.
   logic                       pop_take, sample_take, sample_go, ram_we;
   logic                       issue, term_ok, slot_free, emit_load, last_phase;
   logic [LA_W-1:0]            la_base;
   logic [ADDR_W-1:0]          ram_wr_addr, ram_rd_addr;
   logic [COEF_W-1:0]          coef_raw;
   logic signed [COEF_W-1:0]   coef_rd;
   logic signed [FACT_W:0]     l_signed;
   logic signed [SHIFT_W-1:0]  shifted_re, shifted_im;
   logic                       hi_re, lo_re, hi_im, lo_im;

   // Coefficient store.
   pfi_ram #(
      .WIDTH (COEF_W),
      .DEPTH (STORE_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (pop_item.coef_value),
      .rd_addr (ram_rd_addr),
      .rd_data (coef_raw)
   );

   assign coef_rd  = $signed(coef_raw);
   assign l_signed = $signed({1'b0, l_ff});
   assign la_base  = pop_item.start_of_block ? '0 : la_ff;

   // Sequencer outputs.
   always_comb begin
      pop_ready   = (state_ff == ST_IDLE);
      pop_take    = pop_valid && pop_ready;
      sample_take = pop_take && (pop_item.kind == KIND_SAMPLE);
      sample_go   = sample_take && (la_base == LA_W'(HALF));
      ram_we      = pop_take && (pop_item.kind == KIND_COEF) && pop_item.index_ok;
      ram_wr_addr = ADDR_W'(pop_item.coef_index);
      issue       = (state_ff == ST_READ);
      term_ok     = issue && (ci_ff <= limit_ff);
      ram_rd_addr = term_ok ? ADDR_W'(ci_ff) : '0;
      slot_free   = !out_valid_ff || rsp_ready;
      emit_load   = (state_ff == ST_EMIT) && slot_free;
      last_phase  = ((p_ff + FACT_W'(1)) == l_ff);
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sample_go) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (j_ff == J_W'(PHASE_TAPS)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_load) begin
               state_in = last_phase ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // History shift and lookahead count on each sample.
   always_comb begin
      hist_re_in = hist_re_ff;
      hist_im_in = hist_im_ff;
      la_in      = la_ff;
      if (sample_take) begin
         for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            hist_re_in[i] = pop_item.start_of_block ? '0 : hist_re_ff[i-1];
            hist_im_in[i] = pop_item.start_of_block ? '0 : hist_im_ff[i-1];
         end
         hist_re_in[0] = pop_item.sample_re;
         hist_im_in[0] = pop_item.sample_im;
         la_in = (la_base == LA_W'(HALF)) ? la_base : la_base + LA_W'(1);
      end
   end

   // Counters: phase, coefficient index and tap.
   always_comb begin
      l_in     = l_ff;
      limit_in = limit_ff;
      p_in     = p_ff;
      ci_in    = ci_ff;
      j_in     = j_ff;
      drain_in = (state_ff == ST_DRAIN) ? !drain_ff : 1'b0;
      if (sample_take) begin
         l_in     = act_factor;
         limit_in = CI_W'(PHASE_TAPS) * CI_W'(act_factor);
         p_in     = '0;
         ci_in    = '0;
         j_in     = '0;
      end else if (issue) begin
         j_in  = j_ff + J_W'(1);
         ci_in = ci_ff + CI_W'(l_ff);
      end else if (emit_load && !last_phase) begin
         p_in  = p_ff + FACT_W'(1);
         ci_in = CI_W'(p_ff + FACT_W'(1));
         j_in  = '0;
      end
   end

   // Tap read, product, accumulate and scale by the factor.
   always_comb begin
      s1_in    = term_ok;
      h1_re_in = h1_re_ff;
      h1_im_in = h1_im_ff;
      if (issue) begin
         h1_re_in = hist_re_ff[j_ff];
         h1_im_in = hist_im_ff[j_ff];
      end
      s2_in      = s1_ff;
      prod_re_in = h1_re_ff * coef_rd;
      prod_im_in = h1_im_ff * coef_rd;
      acc_re_in  = acc_re_ff;
      acc_im_in  = acc_im_ff;
      if (s2_ff) begin
         acc_re_in = acc_re_ff + ACC_W'(prod_re_ff);
         acc_im_in = acc_im_ff + ACC_W'(prod_im_ff);
      end
      if (sample_take || emit_load) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end
      scaled_re_in = scaled_re_ff;
      scaled_im_in = scaled_im_ff;
      if (state_ff == ST_SCALE) begin
         scaled_re_in = SCALED_W'(acc_re_ff) * l_signed;
         scaled_im_in = SCALED_W'(acc_im_ff) * l_signed;
      end
   end

   // Floor shift and saturation.
   always_comb begin
      shifted_re = scaled_re_ff[SCALED_W-1:OUT_SHIFT];
      shifted_im = scaled_im_ff[SCALED_W-1:OUT_SHIFT];
      hi_re      = (shifted_re > HI_LIM);
      lo_re      = (shifted_re < LO_LIM);
      hi_im      = (shifted_im > HI_LIM);
      lo_im      = (shifted_im < LO_LIM);
   end

   // Output register: a beat leaves on rsp_ready, a new one loads when the slot frees.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_re_in    = out_re_ff;
      out_im_in    = out_im_ff;
      out_last_in  = out_last_ff;
      out_sat_in   = out_sat_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (emit_load) begin
         out_valid_in = 1'b1;
         out_re_in    = hi_re ? OUT_MAX : (lo_re ? OUT_MIN : shifted_re[SAMPLE_W-1:0]);
         out_im_in    = hi_im ? OUT_MAX : (lo_im ? OUT_MIN : shifted_im[SAMPLE_W-1:0]);
         out_last_in  = last_phase;
         out_sat_in   = hi_re || lo_re || hi_im || lo_im;
      end
   end

   // Control state and history.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         la_ff        <= '0;
         drain_ff     <= 1'b0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_re_ff[i] <= '0;
            hist_im_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         la_ff        <= la_in;
         drain_ff     <= drain_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         out_valid_ff <= out_valid_in;
         hist_re_ff   <= hist_re_in;
         hist_im_ff   <= hist_im_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      l_ff         <= l_in;
      limit_ff     <= limit_in;
      p_ff         <= p_in;
      ci_ff        <= ci_in;
      j_ff         <= j_in;
      h1_re_ff     <= h1_re_in;
      h1_im_ff     <= h1_im_in;
      prod_re_ff   <= prod_re_in;
      prod_im_ff   <= prod_im_in;
      acc_re_ff    <= acc_re_in;
      acc_im_ff    <= acc_im_in;
      scaled_re_ff <= scaled_re_in;
      scaled_im_ff <= scaled_im_in;
      out_re_ff    <= out_re_in;
      out_im_ff    <= out_im_in;
      out_last_ff  <= out_last_in;
      out_sat_ff   <= out_sat_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_re      = out_re_ff;
   assign rsp_out_im      = out_im_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_saturated   = out_sat_ff;

endmodule

### src/polyphase_fir_interpolator.sv
// polyphase_fir_interpolator: top level of the complex polyphase interpolator.
// Depends on pfi_pkg, pfi_front, pfi_queue and pfi_back.
//
//   channel  prefix  direction  beat carries
//   request  req_    in         sample or coefficient write
//   response rsp_    out        one interpolated complex sample
//   control  csr_    in         upsample factor
//
// A coefficient write or a sample still filling the lookahead leaves the back end idle.
// A sample that yields results has one multiply pair walk the 17 taps of each of the L phases;
// each phase then drains the pipeline, is scaled and waits for a free output register.
// Reset is synchronous; it clears the history, the lookahead count and sets the factor to one.
// The coefficient RAM is not cleared; entries must be written before use.
// A two-beat queue parts request intake from the sequencer; a full output register holds it.
module polyphase_fir_interpolator #(
   parameter int MAX_FACTOR = pfi_pkg::MAX_FACTOR_DEF,
   parameter int PHASE_TAPS = pfi_pkg::TAPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic signed [pfi_pkg::SAMPLE_W-1:0]  req_sample_re,
   input  logic signed [pfi_pkg::SAMPLE_W-1:0]  req_sample_im,
   input  logic                                 req_start_of_block,
   input  logic [pfi_pkg::INDEX_W-1:0]          req_coef_index,
   input  logic signed [pfi_pkg::COEF_W-1:0]    req_coef_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pfi_pkg::SAMPLE_W-1:0]  rsp_out_re,
   output logic signed [pfi_pkg::SAMPLE_W-1:0]  rsp_out_im,
   output logic                                 rsp_last_of_run,
   output logic                                 rsp_saturated,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pfi_pkg::FACTOR_W-1:0]         csr_upsample_factor
);
   import pfi_pkg::*;

   localparam int FACT_W = $clog2(MAX_FACTOR + 1);

   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;
   pfi_item_type      push_item, pop_item;
   logic [FACT_W-1:0] act_factor;

   // Intake and classification.
   pfi_front #(
      .MAX_FACTOR (MAX_FACTOR),
      .PHASE_TAPS (PHASE_TAPS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_sample_re       (req_sample_re),
      .req_sample_im       (req_sample_im),
      .req_start_of_block  (req_start_of_block),
      .req_coef_index      (req_coef_index),
      .req_coef_value      (req_coef_value),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_upsample_factor (csr_upsample_factor),
      .push_valid          (push_valid),
      .push_ready          (push_ready),
      .push_item           (push_item),
      .act_factor          (act_factor)
   );

   // Queue between intake and sequencer.
   pfi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // History, coefficients and the multiply-accumulate sequencer.
   pfi_back #(
      .MAX_FACTOR (MAX_FACTOR),
      .PHASE_TAPS (PHASE_TAPS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_item        (pop_item),
      .act_factor      (act_factor),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_re      (rsp_out_re),
      .rsp_out_im      (rsp_out_im),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_saturated   (rsp_saturated)
   );

endmodule

### src/pfi_checker.sv
// pfi_checker: port-level assertions on the response channel of the interpolator.
// Depends on pfi_pkg and assert_macros.svh; bound to polyphase_fir_interpolator below.
`include "assert_macros.svh"

module pfi_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [pfi_pkg::SAMPLE_W-1:0] rsp_out_re,
   input logic signed [pfi_pkg::SAMPLE_W-1:0] rsp_out_im,
   input logic                                rsp_last_of_run,
   input logic                                rsp_saturated
);
   import pfi_pkg::*;

   // A stalled response beat stays put.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_re) && $stable(rsp_out_im) && $stable(rsp_last_of_run) && $stable(rsp_saturated))

   // A clipped beat shows a limit value on at least one part.
   `ASSERT_IMPLY(a_sat_at_limit, clock, reset, rsp_valid && rsp_saturated, rsp_out_re == OUT_MAX || rsp_out_re == OUT_MIN || rsp_out_im == OUT_MAX || rsp_out_im == OUT_MIN)

   // Reset leaves no response beat pending.
   `ASSERT_AFTER_RESET(a_reset_quiet, clock, reset, !rsp_valid)

endmodule

bind polyphase_fir_interpolator pfi_checker u_pfi_checker (.*);

### tb/sv/tb_polyphase_fir_interpolator.sv
// tb_polyphase_fir_interpolator: self-checking testbench of the complex polyphase interpolator.
// Depends on pfi_pkg and polyphase_fir_interpolator; a scoreboard class predicts every output
// beat from the accepted request beats and factor writes.
`timescale 1ns / 100ps

module tb_polyphase_fir_interpolator;
   import pfi_pkg::*;

   localparam int LOOKAHEAD_LEN = TAPS_DEF / 2;
   localparam int HIST_LEN      = TAPS_DEF + 1;
   localparam int BANK_LEN      = MAX_FACTOR_DEF * TAPS_DEF + 1;
   localparam int PLAN_MAX      = 8;
   localparam int COEF_LOAD     = TAPS_DEF * PLAN_MAX + 1;
   localparam int PHASE_BUDGET  = 20;
   localparam int CFG_GAP       = 64;
   localparam int DRAIN_LIMIT   = 200000;
   localparam int HOLD_AFTER    = 120;
   localparam int HOLD_CYCLES   = 1000;
   localparam int PHASES        = 10;
   localparam longint TIMEOUT_NS = 4000000;

   // One interpolated output beat.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
      logic                       last;
      logic                       sat;
   } interp_beat_type;

   // Scoreboard: keeps its own filter state and the queue of output beats still due.
   class interp_scoreboard;
      logic signed [SAMPLE_W-1:0] hist_re [HIST_LEN];
      logic signed [SAMPLE_W-1:0] hist_im [HIST_LEN];
      logic signed [COEF_W-1:0]   coef_bank [BANK_LEN];
      int unsigned                lookahead;
      logic [FACTOR_W-1:0]        factor_reg;
      interp_beat_type            due_beats [$];
      int                         error_count;
      int                         output_count;

      function new();
         foreach (hist_re[i]) begin
            hist_re[i] = '0;
            hist_im[i] = '0;
         end
         foreach (coef_bank[i]) coef_bank[i] = '0;
         lookahead    = 0;
         factor_reg   = FACTOR_RESET;
         error_count  = 0;
         output_count = 0;
      endfunction

      function void take_factor(logic [FACTOR_W-1:0] f);
         factor_reg = f;
      endfunction

      // Zero runs as one, anything above the maximum is clamped.
      function int unsigned live_factor();
         if (factor_reg == 0) return 1;
         if (factor_reg > MAX_FACTOR_DEF) return MAX_FACTOR_DEF;
         return factor_reg;
      endfunction

      function int pending();
         return due_beats.size();
      endfunction

      // Notes one accepted request beat and queues the output beats it causes.
      function void take_request(pfi_kind_type kind, logic signed [SAMPLE_W-1:0] s_re,
                                 logic signed [SAMPLE_W-1:0] s_im, logic sob,
                                 logic [INDEX_W-1:0] idx, logic signed [COEF_W-1:0] val);
         int unsigned     lf;
         int unsigned     ci;
         longint          acc_re;
         longint          acc_im;
         longint          sum_re;
         longint          sum_im;
         interp_beat_type beat;
         if (kind == KIND_COEF) begin
            // Indexes past the bank are dropped.
            if (idx < BANK_LEN) coef_bank[idx] = val;
            return;
         end
         if (sob) begin
            foreach (hist_re[i]) begin
               hist_re[i] = '0;
               hist_im[i] = '0;
            end
            lookahead = 0;
         end
         for (int j = HIST_LEN - 1; j > 0; j--) begin
            hist_re[j] = hist_re[j-1];
            hist_im[j] = hist_im[j-1];
         end
         hist_re[0] = s_re;
         hist_im[0] = s_im;
         // No output until the lookahead half of the history is filled.
         if (lookahead < LOOKAHEAD_LEN) begin
            lookahead++;
            return;
         end
         lf = live_factor();
         for (int unsigned p = 0; p < lf; p++) begin
            acc_re = 0;
            acc_im = 0;
            for (int unsigned j = 0; j < HIST_LEN; j++) begin
               ci = j * lf + p;
               if (ci > TAPS_DEF * lf) continue;
               acc_re += longint'(hist_re[j]) * longint'(coef_bank[ci]) * longint'(lf);
               acc_im += longint'(hist_im[j]) * longint'(coef_bank[ci]) * longint'(lf);
            end
            // Arithmetic shift rounds toward minus infinity, then clip to 16 bits.
            sum_re   = acc_re >>> OUT_SHIFT;
            sum_im   = acc_im >>> OUT_SHIFT;
            beat.sat = 1'b0;
            if (sum_re > 32767) begin
               sum_re = 32767;
               beat.sat = 1'b1;
            end else if (sum_re < -32768) begin
               sum_re = -32768;
               beat.sat = 1'b1;
            end
            if (sum_im > 32767) begin
               sum_im = 32767;
               beat.sat = 1'b1;
            end else if (sum_im < -32768) begin
               sum_im = -32768;
               beat.sat = 1'b1;
            end
            beat.re   = sum_re[SAMPLE_W-1:0];
            beat.im   = sum_im[SAMPLE_W-1:0];
            beat.last = (p == lf - 1);
            due_beats.push_back(beat);
         end
      endfunction

      // Compares one accepted output beat with the oldest one due.
      function void check_output(logic signed [SAMPLE_W-1:0] re, logic signed [SAMPLE_W-1:0] im,
                                 logic last, logic sat);
         interp_beat_type want;
         output_count++;
         if (due_beats.size() == 0) begin
            $error("output beat with none due: out_re %0d out_im %0d", re, im);
            error_count++;
            return;
         end
         want = due_beats.pop_front();
         if (re !== want.re) begin
            $error("out_re mismatch: expected %0d, actual %0d", want.re, re);
            error_count++;
         end
         if (im !== want.im) begin
            $error("out_im mismatch: expected %0d, actual %0d", want.im, im);
            error_count++;
         end
         if (last !== want.last) begin
            $error("last_of_run mismatch: expected %0b, actual %0b", want.last, last);
            error_count++;
         end
         if (sat !== want.sat) begin
            $error("saturated mismatch: expected %0b, actual %0b", want.sat, sat);
            error_count++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_type = KIND_SAMPLE;
   logic signed [SAMPLE_W-1:0] req_sample_re = '0;
   logic signed [SAMPLE_W-1:0] req_sample_im = '0;
   logic                       req_start_of_block = 1'b0;
   logic [INDEX_W-1:0]         req_coef_index = '0;
   logic signed [COEF_W-1:0]   req_coef_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_out_re;
   logic signed [SAMPLE_W-1:0] rsp_out_im;
   logic                       rsp_last_of_run;
   logic                       rsp_saturated;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [FACTOR_W-1:0]        csr_upsample_factor = FACTOR_RESET;

   interp_scoreboard sb = new();
   int idle_pct     = 16;
   int samples_sent = 0;
   int coefs_sent   = 0;
   int factor_sets  = 0;

   polyphase_fir_interpolator u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_sample_re       (req_sample_re),
      .req_sample_im       (req_sample_im),
      .req_start_of_block  (req_start_of_block),
      .req_coef_index      (req_coef_index),
      .req_coef_value      (req_coef_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_re          (rsp_out_re),
      .rsp_out_im          (rsp_out_im),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_saturated       (rsp_saturated),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_upsample_factor (csr_upsample_factor)
   );

   // Clock and a single reset pulse.
   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Run limit.
   initial begin
      #(TIMEOUT_NS);
      $display("[polyphase_fir_interpolator] ERROR");
      $finish;
   end

   // Output receiver: random stalls, plus one long hold-off counted here.
   initial begin
      int  hold_left;
      bit  held;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sb.output_count >= HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   // Output monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_output(rsp_out_re, rsp_out_im, rsp_last_of_run, rsp_saturated);
   end

   // Offers one request beat after a random gap and waits until it is taken.
   task automatic push_request(input pfi_kind_type kind, input logic signed [SAMPLE_W-1:0] s_re,
                               input logic signed [SAMPLE_W-1:0] s_im, input logic sob,
                               input logic [INDEX_W-1:0] idx,
                               input logic signed [COEF_W-1:0] val);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_sample_re      <= s_re;
      req_sample_im      <= s_im;
      req_start_of_block <= sob;
      req_coef_index     <= idx;
      req_coef_value     <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.take_request(kind, s_re, s_im, sob, idx, val);
      if (kind == KIND_COEF) coefs_sent++;
      else samples_sent++;
   endtask

   // Sample beat; the coefficient fields carry noise.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s_re,
                              input logic signed [SAMPLE_W-1:0] s_im, input logic sob);
      push_request(KIND_SAMPLE, s_re, s_im, sob, INDEX_W'($urandom_range(0, 1023)),
                   COEF_W'($urandom_range(0, 262143)));
   endtask

   // Coefficient write beat; the sample fields carry noise.
   task automatic send_coef(input logic [INDEX_W-1:0] idx, input logic signed [COEF_W-1:0] val);
      push_request(KIND_COEF, SAMPLE_W'($urandom_range(0, 65535)),
                   SAMPLE_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), idx, val);
   endtask

   // Loads the first entries of the bank with modest values.
   task automatic load_coefs(input int count);
      for (int i = 0; i < count; i++)
         send_coef(INDEX_W'(i), COEF_W'(int'($urandom_range(0, 4094)) - 2047));
   endtask

   // Waits until every predicted output beat has arrived, with a limit.
   task automatic wait_for_outputs();
      int waited;
      waited = 0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (CFG_GAP) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 19))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Half the writes land in the bank, the rest anywhere in the index range.
   function automatic logic [INDEX_W-1:0] pick_index();
      if ($urandom_range(0, 1)) return INDEX_W'($urandom_range(0, BANK_LEN - 1));
      return INDEX_W'($urandom_range(0, 1023));
   endfunction

   function automatic logic signed [COEF_W-1:0] pick_coef();
      if ($urandom_range(0, 1)) return COEF_W'(int'($urandom_range(0, 4094)) - 2047);
      return COEF_W'($urandom_range(0, 262143));
   endfunction

   // Main sequence: bank load, directed beats, then one random phase per factor setting.
   // Every factor in the plan reads only entries that the initial load has written.
   initial begin
      int                         factor_plan [PHASES];
      logic signed [SAMPLE_W-1:0] edge_re [12];
      logic signed [SAMPLE_W-1:0] edge_im [12];
      logic [FACTOR_W-1:0]        fac;
      int                         sent;
      int                         n;
      int                         r;
      factor_plan = '{4, 8, 0, 2, 6, 3, 1, 7, 5, 8};
      edge_re = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh7FFF, 16'sh8000,
                  16'sh0001, 16'shFFFF, 16'sh4000, 16'sh7FFF, 16'sh0000, 16'sh8000};
      edge_im = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh8000, 16'sh7FFF,
                  16'shFFFF, 16'sh0001, 16'shC000, 16'sh0000, 16'sh8000, 16'sh8000};
      wait (!reset);
      @(posedge clock);
      load_coefs(COEF_LOAD);

      // Directed: coefficient extremes, writes past the bank, sample extremes in a block.
      send_coef(INDEX_W'(0), 18'sh1FFFF);
      send_coef(INDEX_W'(TAPS_DEF), 18'sh20000);
      send_coef(INDEX_W'(BANK_LEN - 1), COEF_W'(5));
      send_coef(INDEX_W'(BANK_LEN), COEF_W'(-1));
      send_coef(INDEX_W'(1023), 18'sh1FFFF);
      for (int i = 0; i < 12; i++) send_sample(edge_re[i], edge_im[i], i == 0);
      for (int i = 0; i < LOOKAHEAD_LEN; i++) send_sample('0, '0, 1'b0);

      for (int ph = 0; ph < PHASES; ph++) begin
         req_valid <= 1'b0;
         wait_for_outputs();
         fac = (ph == 8) ? FACTOR_W'($urandom_range(1, PLAN_MAX)) : FACTOR_W'(factor_plan[ph]);
         csr_valid           <= 1'b1;
         csr_upsample_factor <= fac;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.take_factor(fac);
         factor_sets++;
         csr_valid <= 1'b0;
         // One phase runs without any idle cycles on either side.
         idle_pct = (ph == 3) ? 0 : 16;
         sent     = 0;
         while (sent < PHASE_BUDGET) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
               // Well-formed block: start, random body, zero tail.
               n = $urandom_range(1, 12);
               send_sample(pick_sample(), pick_sample(), 1'b1);
               sent++;
               for (int k = 0; k < n; k++) begin
                  if ($urandom_range(0, 9) == 0) begin
                     send_coef(pick_index(), pick_coef());
                     sent++;
                  end
                  send_sample(pick_sample(), pick_sample(), 1'b0);
                  sent++;
               end
               for (int k = 0; k < LOOKAHEAD_LEN; k++) begin
                  send_sample('0, '0, 1'b0);
                  sent++;
               end
            end else if (r < 88) begin
               send_coef(pick_index(), pick_coef());
               sent++;
            end else begin
               // Lone sample, possibly restarting the block mid-stream.
               send_sample(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
               sent++;
            end
         end
      end

      req_valid <= 1'b0;
      wait_for_outputs();
      if (sb.pending() != 0) begin
         $error("%0d expected output beats never arrived", sb.pending());
         sb.error_count++;
      end
      $display("Covered %0d sample beats, %0d coefficient writes, %0d output beats,",
               samples_sent, coefs_sent, sb.output_count);
      $display("over %0d factor settings including zero, one and factors up to %0d.",
               factor_sets, PLAN_MAX);
      if (sb.error_count == 0) begin
         $display("[polyphase_fir_interpolator] OK");
      end else begin
         $display("[polyphase_fir_interpolator] ERROR");
      end
      $finish;
   end

endmodule
